// ----- rtl/cpcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcd_pkg
// Shared types, constants and small lookup functions for the circle pixel
// coverage block.
// ----------------------------------------------------------------------------
package cpcd_pkg;

  localparam int FRAC_BITS_DEF = 4;

  localparam int PIX_W   = 12;
  localparam int CTR_W   = 16;
  localparam int RAD_W   = 15;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int MODE_W  = 3;
  localparam int COV_W   = 4;
  localparam int BAY_W   = 4;
  localparam int THR_W   = 5;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int RIDX_W  = 3;

  // drawing modes
  localparam logic [MODE_W-1:0] MODE_SOLID      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DITHER     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RING       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DITHER_RING = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AA         = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [RIDX_W-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [RIDX_W-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [RIDX_W-1:0] REG_OUTER_RADIUS   = 3'd2;
  localparam logic [RIDX_W-1:0] REG_RING_THICKNESS = 3'd3;
  localparam logic [RIDX_W-1:0] REG_MODE           = 3'd4;

  localparam logic [BAY_W-1:0] DITHER_LIMIT = 4'd8;
  localparam logic [COV_W-1:0] COV_FULL     = 4'd9;
  localparam logic [COV_W-1:0] COV_NONE     = 4'd0;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic             draw;
    logic [COV_W-1:0] coverage;
  } res_t;

  // configuration as seen by the datapath, squares precomputed
  typedef struct packed {
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [MODE_W-1:0]       mode;
    logic [RSQ_W-1:0]        ro2;
    logic [RSQ_W-1:0]        ri2;
    logic                    ring_ok;
  } cfg_t;

  // 4x4 ordered dither matrix, row from y, column from x
  function automatic logic [BAY_W-1:0] bayer(input logic [1:0] row, input logic [1:0] col);
    logic [BAY_W-1:0] v;
    unique case ({row, col})
      4'h0: v = 4'd0;
      4'h1: v = 4'd8;
      4'h2: v = 4'd2;
      4'h3: v = 4'd10;
      4'h4: v = 4'd12;
      4'h5: v = 4'd4;
      4'h6: v = 4'd14;
      4'h7: v = 4'd6;
      4'h8: v = 4'd3;
      4'h9: v = 4'd11;
      4'ha: v = 4'd1;
      4'hb: v = 4'd9;
      4'hc: v = 4'd15;
      4'hd: v = 4'd7;
      4'he: v = 4'd13;
      4'hf: v = 4'd5;
    endcase
    return v;
  endfunction

  // hits * 16 / 9, truncated
  function automatic logic [THR_W-1:0] cov_thresh(input logic [COV_W-1:0] hits);
    logic [THR_W-1:0] v;
    unique case (hits)
      4'd0:    v = 5'd0;
      4'd1:    v = 5'd1;
      4'd2:    v = 5'd3;
      4'd3:    v = 5'd5;
      4'd4:    v = 5'd7;
      4'd5:    v = 5'd8;
      4'd6:    v = 5'd10;
      4'd7:    v = 5'd12;
      4'd8:    v = 5'd14;
      4'd9:    v = 5'd16;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/cpcd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcd_regs
// APB register file for the circle settings, with the squared outer and
// inner radius kept in registers for the datapath.
// ----------------------------------------------------------------------------
module cpcd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [cpcd_pkg::DATA_W-1:0]   pwdata,
  output logic [cpcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cpcd_pkg::cfg_t                cfg
);

  logic [cpcd_pkg::CTR_W-1:0]  circ_x;
  logic [cpcd_pkg::CTR_W-1:0]  circ_y;
  logic [cpcd_pkg::RAD_W-1:0]  outer_radius;
  logic [cpcd_pkg::RAD_W-1:0]  ring_thickness;
  logic [cpcd_pkg::MODE_W-1:0] mode;
  logic [cpcd_pkg::RSQ_W-1:0]  ro2;
  logic [cpcd_pkg::RSQ_W-1:0]  ri2;
  logic                        ring_ok;

  logic                          wr_en;
  logic [cpcd_pkg::RIDX_W-1:0]   widx;
  logic signed [cpcd_pkg::RAD_W:0] r_in;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = paddr[cpcd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      circ_x         <= '0;
      circ_y         <= '0;
      outer_radius   <= '0;
      ring_thickness <= '0;
      mode           <= cpcd_pkg::MODE_SOLID;
    end else if (wr_en) begin
      unique case (widx)
        cpcd_pkg::REG_CENTER_X:       circ_x         <= pwdata[cpcd_pkg::CTR_W-1:0];
        cpcd_pkg::REG_CENTER_Y:       circ_y         <= pwdata[cpcd_pkg::CTR_W-1:0];
        cpcd_pkg::REG_OUTER_RADIUS:   outer_radius   <= pwdata[cpcd_pkg::RAD_W-1:0];
        cpcd_pkg::REG_RING_THICKNESS: ring_thickness <= pwdata[cpcd_pkg::RAD_W-1:0];
        cpcd_pkg::REG_MODE:           mode           <= pwdata[cpcd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // inner radius, positive only when the band is thinner than the radius
  assign r_in = $signed({1'b0, outer_radius}) - $signed({1'b0, ring_thickness});

  always_ff @(posedge clk) begin
    if (rst) begin
      ro2     <= '0;
      ri2     <= '0;
      ring_ok <= 1'b0;
    end else begin
      ro2     <= cpcd_pkg::RSQ_W'(outer_radius) * cpcd_pkg::RSQ_W'(outer_radius);
      ri2     <= cpcd_pkg::RSQ_W'(r_in[cpcd_pkg::RAD_W-1:0]) *
                 cpcd_pkg::RSQ_W'(r_in[cpcd_pkg::RAD_W-1:0]);
      ring_ok <= (r_in > 0);
    end
  end

  always_comb begin
    prdata = '0;
    unique case (widx)
      cpcd_pkg::REG_CENTER_X:       prdata = cpcd_pkg::DATA_W'(circ_x);
      cpcd_pkg::REG_CENTER_Y:       prdata = cpcd_pkg::DATA_W'(circ_y);
      cpcd_pkg::REG_OUTER_RADIUS:   prdata = cpcd_pkg::DATA_W'(outer_radius);
      cpcd_pkg::REG_RING_THICKNESS: prdata = cpcd_pkg::DATA_W'(ring_thickness);
      cpcd_pkg::REG_MODE:           prdata = cpcd_pkg::DATA_W'(mode);
      default:                      prdata = '0;
    endcase
  end

  assign cfg.cx      = $signed(circ_x);
  assign cfg.cy      = $signed(circ_y);
  assign cfg.mode    = mode;
  assign cfg.ro2     = ro2;
  assign cfg.ri2     = ri2;
  assign cfg.ring_ok = ring_ok;

endmodule

// ----- rtl/circle_pixel_coverage_dither_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pixel_coverage_dither_top
// Per-pixel circle coverage test with ordered dither, ring and 3x3
// anti-aliased modes.
// ----------------------------------------------------------------------------
// The block takes one pixel coordinate per item and returns one result item
// (draw flag and 0..9 coverage) for the circle held in the APB registers.
// It is a four-stage pipeline: offset subtract, squaring, sum and radius
// compare for all nine subsamples, then hit count and mode decision into the
// output register. A new item is taken every cycle while the output is not
// stalled, and its result passes through the stage registers to the output; a stalled output
// holds the pipeline, and bubbles collapse so that items behind an empty
// stage keep moving.
// The rate is one item per clock while the output is not stalled, set by the single pipeline pass; there is
// no memory and no clearing pass after reset. The squared radii are
// recomputed in the cycle after a register write, so settings must be written
// only while no item is in flight.
// ----------------------------------------------------------------------------
module circle_pixel_coverage_dither_top #(
  parameter int FRAC_BITS = cpcd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel items
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  cpcd_pkg::pix_t                pix,
  // result items
  output logic                          res_valid,
  input  logic                          res_stall,
  output cpcd_pkg::res_t                res,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [cpcd_pkg::DATA_W-1:0]   pwdata,
  output logic [cpcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // offset width: sample position or centre, plus room for the subtraction
  localparam int POS_W  = cpcd_pkg::PIX_W + FRAC_BITS;
  localparam int DW     = ((POS_W > cpcd_pkg::CTR_W) ? POS_W : cpcd_pkg::CTR_W) + 2;
  localparam int SQW    = 2 * DW;
  localparam int NSUB   = 3;
  localparam int NHIT   = NSUB * NSUB;
  localparam int CENTER = NHIT / 2;
  localparam int SCALE  = 1 << FRAC_BITS;
  localparam logic signed [DW-1:0] HALF  = DW'(SCALE / 2);
  localparam logic signed [DW-1:0] THIRD = DW'(SCALE / 3);

  cpcd_pkg::cfg_t cfg;

  cpcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage valid bits
  logic v1, v2, v3;

  // stage advance: a stage moves when it is empty or the next one moves
  logic en1, en2, en3, en4;

  assign en4       = !res_valid || !res_stall;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign pix_stall = !en1;

  // ---------------------------------------------------------------- stage 1
  // sample centre in fixed point, minus the circle centre, at three offsets
  logic signed [DW-1:0]          dx1 [NSUB];
  logic signed [DW-1:0]          dy1 [NSUB];
  logic [cpcd_pkg::BAY_W-1:0]    bay1;
  logic signed [DW-1:0]          sx;
  logic signed [DW-1:0]          sy;
  logic signed [DW-1:0]          ddx;
  logic signed [DW-1:0]          ddy;

  always_comb begin
    sx  = (DW'(pix.pixel_x) <<< FRAC_BITS) + HALF;
    sy  = (DW'(pix.pixel_y) <<< FRAC_BITS) + HALF;
    ddx = sx - DW'(cfg.cx);
    ddy = sy - DW'(cfg.cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && pix_valid) begin
      dx1[0] <= ddx - THIRD;
      dx1[1] <= ddx;
      dx1[2] <= ddx + THIRD;
      dy1[0] <= ddy - THIRD;
      dy1[1] <= ddy;
      dy1[2] <= ddy + THIRD;
      bay1   <= cpcd_pkg::bayer(pix.pixel_y[1:0], pix.pixel_x[1:0]);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // six squarers, one per row and column offset
  logic [SQW-1:0]             dx2 [NSUB];
  logic [SQW-1:0]             dy2 [NSUB];
  logic [cpcd_pkg::BAY_W-1:0] bay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int k = 0; k < NSUB; k++) begin
        dx2[k] <= SQW'(dx1[k]) * SQW'(dx1[k]);
        dy2[k] <= SQW'(dy1[k]) * SQW'(dy1[k]);
      end
      bay2 <= bay1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // distance squared per subsample against the outer radius; the centre
  // sample also checks the inner radius for ring modes
  logic [NHIT-1:0]            hit3;
  logic                       ge_in3;
  logic [cpcd_pkg::BAY_W-1:0] bay3;
  logic [SQW-1:0]             d2 [NHIT];
  logic [NHIT-1:0]            hit_c;

  always_comb begin
    for (int i = 0; i < NSUB; i++) begin
      for (int j = 0; j < NSUB; j++) begin
        d2[i*NSUB+j]    = dx2[j] + dy2[i];
        hit_c[i*NSUB+j] = (d2[i*NSUB+j] <= SQW'(cfg.ro2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      hit3   <= hit_c;
      ge_in3 <= (d2[CENTER] >= SQW'(cfg.ri2));
      bay3   <= bay2;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // count hits and apply the mode rules
  logic [cpcd_pkg::COV_W-1:0] hits;
  logic [cpcd_pkg::THR_W-1:0] thr;
  logic                       blocked;
  logic                       in_band;
  logic                       draw_c;
  logic [cpcd_pkg::COV_W-1:0] cov_c;

  always_comb begin
    hits = '0;
    for (int k = 0; k < NHIT; k++) begin
      hits = hits + cpcd_pkg::COV_W'(hit3[k]);
    end
    thr     = cpcd_pkg::cov_thresh(hits);
    blocked = (bay3 >= cpcd_pkg::DITHER_LIMIT);
    // thin ring falls back to the full disc
    in_band = hit3[CENTER] && (!cfg.ring_ok || ge_in3);
    draw_c  = 1'b0;
    unique case (cfg.mode)
      cpcd_pkg::MODE_SOLID:       draw_c = hit3[CENTER];
      cpcd_pkg::MODE_DITHER:      draw_c = hit3[CENTER] && !blocked;
      cpcd_pkg::MODE_RING:        draw_c = in_band;
      cpcd_pkg::MODE_DITHER_RING: draw_c = in_band && !blocked;
      cpcd_pkg::MODE_AA:          draw_c = (hits == cpcd_pkg::COV_FULL) ||
                                           ({1'b0, bay3} < thr);
      default:                    draw_c = 1'b0;
    endcase
    if (cfg.mode == cpcd_pkg::MODE_AA) begin
      cov_c = hits;
    end else begin
      cov_c = draw_c ? cpcd_pkg::COV_FULL : cpcd_pkg::COV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en4) begin
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      res.draw     <= draw_c;
      res.coverage <= cov_c;
    end
  end

  // ------------------------------------------------------------- assertions
  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.coverage <= cpcd_pkg::COV_FULL))
    else $error("coverage above nine");

  a_draw_cov: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.draw) |-> (res.coverage != cpcd_pkg::COV_NONE))
    else $error("drawn pixel with zero coverage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && res_valid && res_stall) |-> pix_stall)
    else $error("full pipeline did not stall input");

  a_empty_out: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !pix_stall)
    else $error("input stalled with empty output");

endmodule

// ----- tb/circle_pixel_coverage_dither_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pixel_coverage_dither_top_tb
// Self-checking bench for the circle pixel coverage block: every accepted
// pixel item is scored by an in-bench coverage predictor, and each result
// item is compared in order against the predicted draw flag and coverage.
// Directed cases cover reset state, zero radius, coordinate extremes, dither,
// ring and thin-ring fallback, anti-aliased edges and unused modes; random
// circle settings follow, with bursty pixel traffic and output stalls.
// ----------------------------------------------------------------------------
module circle_pixel_coverage_dither_top_tb;

  localparam int CLK_HALF = 5;
  localparam int FRAC     = cpcd_pkg::FRAC_BITS_DEF;
  localparam longint SUB_SCALE = longint'(1) << FRAC;
  localparam longint SUB_HALF  = SUB_SCALE / 2;
  localparam longint SUB_THIRD = SUB_SCALE / 3;
  localparam int SUBSAMPLES = 9;
  localparam int COV_SCALE  = 16;
  // bayer entries packed by index row*4+col, entry 0 in the low nibble
  localparam logic [63:0] DITHER_MAP = 64'h5D7F_91B3_6E4C_A280;
  // mode codes the block treats as unused
  localparam logic [cpcd_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [cpcd_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [cpcd_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam int DRAIN_CYCLES = 8;      // outlasts the four-stage pipeline
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_PHASES = 20;
  localparam int ITEMS_PER_PHASE = 50;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

  // one pending item: the pixel sent and the result it must produce
  typedef struct packed {
    cpcd_pkg::pix_t pixel;
    cpcd_pkg::res_t want;
  } cov_expect_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          pix_valid;
  logic                          pix_stall;
  cpcd_pkg::pix_t                pix;
  logic                          res_valid;
  logic                          res_stall;
  cpcd_pkg::res_t                res;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cpcd_pkg::ADDR_W-1:0]   paddr;
  logic [cpcd_pkg::DATA_W-1:0]   pwdata;
  logic [cpcd_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // bench copy of the circle registers, reset values
  logic signed [cpcd_pkg::CTR_W-1:0] cfg_cx    = '0;
  logic signed [cpcd_pkg::CTR_W-1:0] cfg_cy    = '0;
  logic [cpcd_pkg::RAD_W-1:0]        cfg_ro    = '0;
  logic [cpcd_pkg::RAD_W-1:0]        cfg_thick = '0;
  logic [cpcd_pkg::MODE_W-1:0]       cfg_mode  = cpcd_pkg::MODE_SOLID;

  cov_expect_t cov_expect_q[$];
  cov_expect_t head;

  int err_count      = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int drawn_count    = 0;
  int aa_items       = 0;
  int ring_items     = 0;
  int settings_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  bit quiet          = 1'b0;   // no sender gaps and no output stalls

  stall_kind_t stall_kind = STALL_NONE;
  int stall_left  = 0;
  int stall_phase = 0;

  circle_pixel_coverage_dither_top #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  // run guard, counts every cycle from time zero
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d items still pending", $time, CYCLE_LIMIT,
               cov_expect_q.size());
      $display("circle_pixel_coverage_dither_top_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // coverage predictor
  // ---------------------------------------------------------------------------

  // squared distance from a subsample point to the circle centre
  function automatic longint center_dist2(input longint ax, input longint ay);
    longint dx;
    longint dy;
    dx = ax - longint'(cfg_cx);
    dy = ay - longint'(cfg_cy);
    return dx * dx + dy * dy;
  endfunction

  function automatic cpcd_pkg::res_t predict_coverage(input cpcd_pkg::pix_t p);
    longint sx;
    longint sy;
    longint r_out;
    longint r_in;
    longint ro2;
    longint d2;
    int hits;
    int k;
    logic [cpcd_pkg::BAY_W-1:0] bay;
    bit dith;
    bit ring;
    bit draw;
    cpcd_pkg::res_t r;
    // sample at the pixel centre
    sx = longint'($signed(p.pixel_x)) * SUB_SCALE + SUB_HALF;
    sy = longint'($signed(p.pixel_y)) * SUB_SCALE + SUB_HALF;
    r_out = longint'(cfg_ro);
    r_in  = r_out - longint'(cfg_thick);
    ro2   = r_out * r_out;
    k     = {p.pixel_y[1:0], p.pixel_x[1:0]};
    bay   = DITHER_MAP[k*4 +: 4];
    draw  = 1'b0;
    hits  = 0;
    if (cfg_mode == cpcd_pkg::MODE_AA) begin
      // 3x3 grid at -third, 0, +third of a pixel around the centre
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (center_dist2(sx + (j - 1) * SUB_THIRD, sy + (i - 1) * SUB_THIRD) <= ro2) hits++;
        end
      end
      draw = (hits == SUBSAMPLES) || (int'(bay) < (hits * COV_SCALE) / SUBSAMPLES);
      r.coverage = cpcd_pkg::COV_W'(hits);
    end else begin
      if (cfg_mode <= cpcd_pkg::MODE_DITHER_RING) begin
        dith = (cfg_mode == cpcd_pkg::MODE_DITHER) || (cfg_mode == cpcd_pkg::MODE_DITHER_RING);
        // a band with no inside falls back to the plain disc
        ring = ((cfg_mode == cpcd_pkg::MODE_RING) ||
                (cfg_mode == cpcd_pkg::MODE_DITHER_RING)) && (r_in > 0);
        d2 = center_dist2(sx, sy);
        if (!(dith && bay >= cpcd_pkg::DITHER_LIMIT)) begin
          if (ring) draw = (d2 <= ro2) && (d2 >= r_in * r_in);
          else      draw = d2 <= ro2;
        end
      end
      r.coverage = draw ? cpcd_pkg::COV_FULL : cpcd_pkg::COV_NONE;
    end
    r.draw = draw;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (cov_expect_q.size() == 0) begin
        err_count++;
        $display("%0t: result item with none pending: draw %0d coverage %0d", $time,
                 res.draw, res.coverage);
      end else begin
        head = cov_expect_q.pop_front();
        if (res.draw !== head.want.draw) begin
          err_count++;
          $display("%0t: draw mismatch at pixel (%0d,%0d): expected %0d actual %0d", $time,
                   $signed(head.pixel.pixel_x), $signed(head.pixel.pixel_y),
                   head.want.draw, res.draw);
        end
        if (res.coverage !== head.want.coverage) begin
          err_count++;
          $display("%0t: coverage mismatch at pixel (%0d,%0d): expected %0d actual %0d", $time,
                   $signed(head.pixel.pixel_x), $signed(head.pixel.pixel_y),
                   head.want.coverage, res.coverage);
        end
        if (head.want.draw) drawn_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stall pattern: the kind of stalling is drawn again at random each time its run ends
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    stall_phase++;
    if (quiet) begin
      res_stall <= 1'b0;
    end else begin
      case (stall_kind)
        STALL_NONE:     res_stall <= 1'b0;
        STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    res_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: res_stall <= (stall_phase % 3 == 0);
        default:        res_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic reg_write(input logic [cpcd_pkg::RIDX_W-1:0] idx,
                           input logic [cpcd_pkg::DATA_W-1:0] data);
    // setup cycle
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    // access cycle, register takes the data when pready is seen
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bench copy keeps only the register's own bits
    case (idx)
      cpcd_pkg::REG_CENTER_X:       cfg_cx    = data[cpcd_pkg::CTR_W-1:0];
      cpcd_pkg::REG_CENTER_Y:       cfg_cy    = data[cpcd_pkg::CTR_W-1:0];
      cpcd_pkg::REG_OUTER_RADIUS:   cfg_ro    = data[cpcd_pkg::RAD_W-1:0];
      cpcd_pkg::REG_RING_THICKNESS: cfg_thick = data[cpcd_pkg::RAD_W-1:0];
      cpcd_pkg::REG_MODE:           cfg_mode  = data[cpcd_pkg::MODE_W-1:0];
      default: ;
    endcase
  endtask

  // write the whole circle, with junk above each field's width
  task automatic set_circle(input logic [cpcd_pkg::CTR_W-1:0] cx,
                            input logic [cpcd_pkg::CTR_W-1:0] cy,
                            input logic [cpcd_pkg::RAD_W-1:0] r,
                            input logic [cpcd_pkg::RAD_W-1:0] thick,
                            input logic [cpcd_pkg::MODE_W-1:0] m);
    logic [cpcd_pkg::DATA_W-1:0] junk;
    junk = $urandom;
    reg_write(cpcd_pkg::REG_CENTER_X, {junk[cpcd_pkg::DATA_W-1:cpcd_pkg::CTR_W], cx});
    reg_write(cpcd_pkg::REG_CENTER_Y, {junk[cpcd_pkg::DATA_W-1:cpcd_pkg::CTR_W], cy});
    reg_write(cpcd_pkg::REG_OUTER_RADIUS, {junk[cpcd_pkg::DATA_W-1:cpcd_pkg::RAD_W], r});
    reg_write(cpcd_pkg::REG_RING_THICKNESS, {junk[cpcd_pkg::DATA_W-1:cpcd_pkg::RAD_W], thick});
    reg_write(cpcd_pkg::REG_MODE, {junk[cpcd_pkg::DATA_W-1:cpcd_pkg::MODE_W], m});
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // pixel sender: bursts of random length with random gaps between
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input cpcd_pkg::pix_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (!quiet && $urandom_range(0, 15) == 0) gap = 20;
      repeat (gap) begin
        @(negedge clk);
        pix_valid <= 1'b0;
      end
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (pix_stall);
    // accepted at this edge
    cov_expect_q.push_back('{pixel: p, want: predict_coverage(p)});
    items_sent++;
    if (cfg_mode == cpcd_pkg::MODE_AA) aa_items++;
    if (cfg_mode == cpcd_pkg::MODE_RING || cfg_mode == cpcd_pkg::MODE_DITHER_RING) ring_items++;
    burst_left--;
  endtask

  task automatic send_xy(input int x, input int y);
    cpcd_pkg::pix_t p;
    p.pixel_x = cpcd_pkg::PIX_W'(x);
    p.pixel_y = cpcd_pkg::PIX_W'(y);
    send_pixel(p);
  endtask

  // drop valid and let every pending result come back, block is then idle
  task automatic finish_phase();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (cov_expect_q.size() != 0) @(posedge clk);
  endtask

  // mostly pixels around the current circle, some anywhere on the plane
  function automatic cpcd_pkg::pix_t pick_pixel();
    cpcd_pkg::pix_t p;
    logic [$bits(cpcd_pkg::pix_t)-1:0] raw;
    int cpx;
    int cpy;
    int span;
    if ($urandom_range(0, 4) == 0) begin
      raw = $bits(cpcd_pkg::pix_t)'($urandom);
      p = raw;
    end else begin
      cpx  = int'(cfg_cx) >>> FRAC;
      cpy  = int'(cfg_cy) >>> FRAC;
      span = int'(cfg_ro >> FRAC) + 3;
      p.pixel_x = cpcd_pkg::PIX_W'(cpx + int'($urandom_range(0, 2 * span)) - span);
      p.pixel_y = cpcd_pkg::PIX_W'(cpy + int'($urandom_range(0, 2 * span)) - span);
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers straight out of reset: zero radius at the origin
  task automatic test_reset_state();
    send_xy(0, 0);
    send_xy(-1, -1);
    finish_phase();
  endtask

  // zero radius: only a sample exactly on the centre hits
  task automatic test_zero_radius();
    set_circle(16'sd8, 16'sd8, 15'd0, 15'd0, cpcd_pkg::MODE_SOLID);
    send_xy(0, 0);
    send_xy(1, 0);
    finish_phase();
    set_circle(16'sd8, 16'sd8, 15'd0, 15'd0, cpcd_pkg::MODE_AA);
    send_xy(0, 0);
    finish_phase();
  endtask

  // most negative and most positive coordinates, largest radius
  task automatic test_extremes();
    set_circle(16'sh8000, 16'sh7FFF, 15'h7FFF, 15'h7FFF, cpcd_pkg::MODE_SOLID);
    send_xy(-2048, 2047);
    send_xy(2047, -2048);
    send_xy(-2048, -2048);
    finish_phase();
  endtask

  // dither suppression, thin-ring fallback, proper band, zero-width band
  task automatic test_dither_and_ring();
    set_circle(16'sd0, 16'sd0, 15'h7FFF, 15'd0, cpcd_pkg::MODE_DITHER);
    send_xy(0, 0);
    send_xy(1, 0);
    send_xy(2, 1);
    send_xy(3, 3);
    finish_phase();
    set_circle(16'sd0, 16'sd0, 15'd160, 15'd200, cpcd_pkg::MODE_RING);
    send_xy(0, 0);
    send_xy(20, 0);
    finish_phase();
    set_circle(16'sd0, 16'sd0, 15'd160, 15'd32, cpcd_pkg::MODE_DITHER_RING);
    send_xy(0, 0);
    send_xy(8, 0);
    send_xy(9, 0);
    finish_phase();
    // band of width zero: only a sample exactly on the radius
    set_circle(16'sd0, 16'sd8, 15'd136, 15'd0, cpcd_pkg::MODE_RING);
    send_xy(8, 0);
    send_xy(7, 0);
    finish_phase();
  endtask

  // partial subsample coverage along the rim
  task automatic test_antialias_edge();
    set_circle(16'sd0, 16'sd0, 15'd50, 15'd0, cpcd_pkg::MODE_AA);
    send_xy(3, 0);
    send_xy(2, 2);
    send_xy(0, 0);
    finish_phase();
  endtask

  // codes past the anti-aliased mode draw nothing
  task automatic test_unused_modes();
    set_circle(16'sd0, 16'sd0, 15'h7FFF, 15'd0, MODE_SPARE_5);
    send_xy(0, 0);
    finish_phase();
    set_circle(16'sd0, 16'sd0, 15'h7FFF, 15'd0, MODE_SPARE_6);
    send_xy(0, 0);
    finish_phase();
    set_circle(16'sd0, 16'sd0, 15'h7FFF, 15'd0, MODE_SPARE_7);
    send_xy(0, 0);
    finish_phase();
  endtask

  // random circles, mostly small so that rims are crossed often
  task automatic test_random_circles();
    logic [cpcd_pkg::CTR_W-1:0] cx;
    logic [cpcd_pkg::CTR_W-1:0] cy;
    logic [cpcd_pkg::RAD_W-1:0] r;
    logic [cpcd_pkg::RAD_W-1:0] thick;
    logic [cpcd_pkg::MODE_W-1:0] m;
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cx = cpcd_pkg::CTR_W'($urandom);
      cy = cpcd_pkg::CTR_W'($urandom);
      case ($urandom_range(0, 5))
        0:       r = cpcd_pkg::RAD_W'($urandom_range(0, 8));
        1, 2:    r = cpcd_pkg::RAD_W'($urandom_range(0, 96));
        3:       r = cpcd_pkg::RAD_W'($urandom_range(0, 2048));
        4:       r = cpcd_pkg::RAD_W'($urandom);
        default: r = '1;
      endcase
      case ($urandom_range(0, 4))
        0:       thick = '0;
        1:       thick = cpcd_pkg::RAD_W'($urandom_range(0, r));
        2:       thick = cpcd_pkg::RAD_W'($urandom_range(0, int'(r) + 64));
        3:       thick = cpcd_pkg::RAD_W'($urandom);
        default: thick = '1;
      endcase
      pick = $urandom_range(0, 11);
      m = (pick < 10) ? cpcd_pkg::MODE_W'(pick % 5) : cpcd_pkg::MODE_W'($urandom_range(5, 7));
      set_circle(cx, cy, r, thick, m);
      repeat (ITEMS_PER_PHASE) send_pixel(pick_pixel());
      finish_phase();
    end
  endtask

  // full rate with no gaps and no stalls
  task automatic test_back_to_back();
    quiet = 1'b1;
    set_circle(16'sd40, -16'sd24, 15'd48, 15'd20, cpcd_pkg::MODE_DITHER_RING);
    repeat (60) send_pixel(pick_pixel());
    finish_phase();
    set_circle(-16'sd100, 16'sd300, 15'd70, 15'd0, cpcd_pkg::MODE_AA);
    repeat (60) send_pixel(pick_pixel());
    finish_phase();
    quiet = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    pix_valid = 1'b0;
    pix       = '0;
    res_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_zero_radius();
    test_extremes();
    test_dither_and_ring();
    test_antialias_edge();
    test_unused_modes();
    test_random_circles();
    test_back_to_back();

    // late or extra results would show up here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixel items over %0d circle settings, %0d results checked",
             items_sent, settings_count, results_seen);
    $display("  %0d drawn, %0d in ring modes, %0d anti-aliased", drawn_count, ring_items,
             aa_items);
    if (err_count == 0) begin
      $display("circle_pixel_coverage_dither_top_tb: clean");
    end else begin
      $display("circle_pixel_coverage_dither_top_tb: errors");
    end
    $finish;
  end

endmodule
